FILE: rtl/core/chunked_free_list_allocator_core_defines.svh
// assertion macros for the free list allocator core
`ifndef CHUNKED_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define CHUNKED_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define CFLA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define CFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cfla_pkg.sv
// shared types and codes for the free list allocator core
package cfla_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_ALLOC,
        S_GROW,
        S_POP
    } state_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

    localparam logic CFG_MAX_OBJECTS = 1'b0;
    localparam logic CFG_CHUNK_SIZE  = 1'b1;

    localparam int CFG_W = 11;
    localparam int IDX_W = 10;

    localparam logic [CFG_W-1:0] MAX_OBJECTS_RESET = 11'd1024;
    localparam logic [CFG_W-1:0] CHUNK_SIZE_RESET  = 11'd16;

endpackage

FILE: rtl/core/chunked_free_list_allocator_core.sv
// free list object pool allocator with a link memory and lazy chunk growth
//
// channel   direction  handshake                  payload
// -------   ---------  -------------------------  -------------------------
// request   in         start && !busy             opcode, free_index
// result    out        done (one cycle, no stall)  object_index, status
// config    in         cfg_valid && cfg_ready     cfg_index, cfg_data
//
// a free does one link write in the free state, then returns to idle with its result
// an allocate from a non-empty list first decides and issues the link read,
//   then takes the registered read data and writes the end marker
// an allocate that finds the list empty and nothing left to create answers from the decide state
// an allocate on an empty list adds one link write per new object plus a second
//   decide state; the writes go one object at a time, set by the single write
//   port of the link memory
// reset empties the head, clears the created count and sets the config registers to their
//   defaults; the link memory is not cleared since every link is written before it is read
// results cannot be stalled; cfg_ready is always high
`include "chunked_free_list_allocator_core_defines.svh"

module chunked_free_list_allocator_core
    import cfla_pkg::*;
#(
    parameter int MAX_OBJECTS = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             opcode,
    input  logic [IDX_W-1:0] free_index,
    output logic             done,
    output logic [IDX_W-1:0] object_index,
    output logic             status,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // link width holds every index plus the end-of-list marker
    localparam int LINK_W = $clog2(MAX_OBJECTS + 1);
    localparam int ADDR_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CMP_W  = (LINK_W > CFG_W) ? LINK_W : CFG_W;

    localparam logic [LINK_W-1:0] END_C = LINK_W'(MAX_OBJECTS);
    localparam logic [CMP_W-1:0]  MAX_C = CMP_W'(MAX_OBJECTS);
    localparam logic [CMP_W-1:0]  ONE_C = CMP_W'(1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  max_objects_reg;
    logic [CFG_W-1:0]  chunk_size_reg;

    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] created_reg, created_next;
    logic [LINK_W-1:0] grow_ptr_reg, grow_ptr_next;
    logic [LINK_W-1:0] grow_end_reg, grow_end_next;

    // latched request
    logic              op_reg;
    logic [IDX_W-1:0]  idx_reg;

    // result registers
    logic              done_reg, done_next;
    logic [IDX_W-1:0]  obj_reg, obj_next;
    logic              status_reg, status_next;

    // link memory
    logic [LINK_W-1:0] link_mem [MAX_OBJECTS];
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [LINK_W-1:0] rd_data_reg;

    // growth sizing
    logic [CMP_W-1:0]  max_ext;
    logic [CMP_W-1:0]  limit;
    logic [CMP_W-1:0]  created_ext;
    logic [CMP_W-1:0]  chunk_eff;
    logic [CMP_W-1:0]  remaining;
    logic [CMP_W-1:0]  amount;
    logic [CMP_W-1:0]  head_ext;
    logic              head_empty;
    logic              can_grow;
    logic              grow_last;
    logic [LINK_W-1:0] grow_succ;

    logic              accept;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign done         = done_reg;
    assign object_index = obj_reg;
    assign status       = status_reg;

    // limit saturates at capacity, a zero chunk counts as one
    assign max_ext     = CMP_W'(max_objects_reg);
    assign limit       = (max_ext > MAX_C) ? MAX_C : max_ext;
    assign created_ext = CMP_W'(created_reg);
    assign chunk_eff   = (chunk_size_reg == '0) ? ONE_C : CMP_W'(chunk_size_reg);
    assign remaining   = limit - created_ext;
    assign amount      = (chunk_eff < remaining) ? chunk_eff : remaining;
    assign can_grow    = (created_ext < limit);
    assign head_ext    = CMP_W'(head_reg);
    assign head_empty  = (head_ext >= MAX_C);

    assign grow_succ = grow_ptr_reg + LINK_W'(1);
    assign grow_last = (grow_succ == grow_end_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (opcode == OP_FREE) ? S_FREE : S_ALLOC;
                end
            end
            S_FREE:
            begin
                state_next = S_IDLE;
            end
            S_ALLOC:
            begin
                if (!head_empty)
                begin
                    state_next = S_POP;
                end
                else if (can_grow)
                begin
                    state_next = S_GROW;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_GROW:
            begin
                if (grow_last)
                begin
                    state_next = S_ALLOC;
                end
            end
            S_POP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, memory controls and result
    always_comb
    begin
        head_next     = head_reg;
        created_next  = created_reg;
        grow_ptr_next = grow_ptr_reg;
        grow_end_next = grow_end_reg;
        wr_en         = 1'b0;
        wr_addr       = head_reg[ADDR_W-1:0];
        wr_data       = END_C;
        rd_en         = 1'b0;
        rd_addr       = head_reg[ADDR_W-1:0];
        done_next     = 1'b0;
        obj_next      = obj_reg;
        status_next   = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_FREE:
            begin
                // out-of-range index is dropped but still answered
                if (CMP_W'(idx_reg) < MAX_C)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = ADDR_W'(idx_reg);
                    wr_data   = head_reg;
                    head_next = LINK_W'(CMP_W'(idx_reg));
                end
                done_next   = 1'b1;
                obj_next    = '0;
                status_next = STATUS_OK;
            end
            S_ALLOC:
            begin
                if (!head_empty)
                begin
                    rd_en = 1'b1;
                end
                else if (can_grow)
                begin
                    grow_ptr_next = created_reg;
                    grow_end_next = LINK_W'(created_ext + amount);
                end
                else
                begin
                    done_next   = 1'b1;
                    obj_next    = '0;
                    status_next = STATUS_EXHAUSTED;
                end
            end
            S_GROW:
            begin
                // chain new objects in ascending order, last one onto old head
                wr_en         = 1'b1;
                wr_addr       = grow_ptr_reg[ADDR_W-1:0];
                wr_data       = grow_last ? head_reg : grow_succ;
                grow_ptr_next = grow_succ;
                if (grow_last)
                begin
                    head_next    = created_reg;
                    created_next = grow_end_reg;
                end
            end
            S_POP:
            begin
                wr_en       = 1'b1;
                wr_addr     = head_reg[ADDR_W-1:0];
                wr_data     = END_C;
                head_next   = rd_data_reg;
                done_next   = 1'b1;
                obj_next    = head_ext[IDX_W-1:0];
                status_next = STATUS_OK;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= END_C;
            created_reg     <= '0;
            done_reg        <= 1'b0;
            max_objects_reg <= MAX_OBJECTS_RESET;
            chunk_size_reg  <= CHUNK_SIZE_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            created_reg <= created_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MAX_OBJECTS: max_objects_reg <= cfg_data;
                    CFG_CHUNK_SIZE:  chunk_size_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        grow_ptr_reg <= grow_ptr_next;
        grow_end_reg <= grow_end_next;
        obj_reg      <= obj_next;
        status_reg   <= status_next;
        if (accept)
        begin
            op_reg  <= opcode;
            idx_reg <= free_index;
        end
    end

    // link memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    // an accepted request always leaves idle
    `CFLA_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not start")

    // free state only entered for a latched free request
    `CFLA_ASSERT_NOW(a_free_op, state_reg == S_FREE, op_reg == OP_FREE, "free state without free")

    // growth only runs while the free list is empty
    `CFLA_ASSERT_NOW(a_grow_empty, state_reg == S_GROW, head_empty, "growth with non-empty list")

    // created count never passes capacity
    `CFLA_ASSERT_NOW(a_created_cap, 1'b1, CMP_W'(created_reg) <= MAX_C, "created count past capacity")

endmodule

FILE: dv/chunked_free_list_allocator_core_tb.sv
// self-checking testbench for the free list object pool allocator core
`timescale 1ns / 1ps

module chunked_free_list_allocator_core_tb;
    import cfla_pkg::*;

    // pool capacity, also the end-of-list marker in the link memory
    localparam int POOL_DEPTH = 1024;
    // items per random phase
    localparam int PHASE_ITEMS = 330;
    // settle cycles once the result stream has drained
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    // one result as the block reports it
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             status;
    } grant_t;

    // one line of the directed script
    typedef struct packed {
        row_kind_t        kind;
        logic             op;
        logic [IDX_W-1:0] idx;
        logic             reg_sel;
        logic [CFG_W-1:0] reg_val;
        logic             typed;
        grant_t           want;
    } stim_row_t;

    // random phase setting: limit and chunk
    typedef struct packed {
        logic [CFG_W-1:0] limit;
        logic [CFG_W-1:0] chunk;
    } pool_setting_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             opcode;
    logic [IDX_W-1:0] free_index;
    logic             done;
    logic [IDX_W-1:0] object_index;
    logic             status;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // shadow of the pool: links, head, created count and the two registers
    logic [CFG_W-1:0] link_mem [POOL_DEPTH];
    logic [CFG_W-1:0] head;
    logic [CFG_W-1:0] created;
    logic [CFG_W-1:0] limit_reg;
    logic [CFG_W-1:0] chunk_reg;

    // grants still owed by the block, oldest first
    grant_t           grant_q [$];
    // indices handed out and not yet returned, used for well-formed frees
    logic [IDX_W-1:0] held [$];
    stim_row_t        script [$];

    int errors;
    int n_alloc;
    int n_free;
    int n_exhausted;
    int n_growth;

    chunked_free_list_allocator_core #(
        .MAX_OBJECTS(POOL_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .free_index(free_index),
        .done(done),
        .object_index(object_index),
        .status(status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #400_000;
        $display("Verification failed");
        $finish;
    end

    // next grant of the pool for one request; updates the shadow state
    function automatic grant_t pool_step(logic op, logic [IDX_W-1:0] idx);
        grant_t g;
        int     cap;
        int     amount;
        int     first;
        g.index  = '0;
        g.status = STATUS_OK;
        if (op == OP_FREE)
        begin
            // pushed with no check, so double frees go on the list too
            link_mem[idx] = head;
            head          = CFG_W'(idx);
            return g;
        end
        if (head >= POOL_DEPTH)
        begin
            // empty list: grow by a chunk, limit saturated at capacity
            cap = (limit_reg > POOL_DEPTH) ? POOL_DEPTH : int'(limit_reg);
            if (created >= cap)
            begin
                g.status = STATUS_EXHAUSTED;
                return g;
            end
            amount = cap - int'(created);
            // a chunk of zero behaves as a chunk of one
            if (chunk_reg == 0)
                amount = 1;
            else if (chunk_reg < amount)
                amount = int'(chunk_reg);
            first = int'(created);
            for (int k = 0; k + 1 < amount; k++)
                link_mem[first + k] = CFG_W'(first + k + 1);
            link_mem[first + amount - 1] = head;
            head     = CFG_W'(first);
            created  = CFG_W'(first + amount);
            n_growth = n_growth + 1;
        end
        g.index           = head[IDX_W-1:0];
        head              = link_mem[g.index];
        link_mem[g.index] = CFG_W'(POOL_DEPTH);
        return g;
    endfunction

    function automatic stim_row_t req_row(logic op, logic [IDX_W-1:0] idx);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_REQ;
        r.op      = op;
        r.idx     = idx;
        return r;
    endfunction

    function automatic stim_row_t chk_row(logic op, logic [IDX_W-1:0] idx,
                                          logic [IDX_W-1:0] want_idx, logic want_st);
        stim_row_t r;
        r              = req_row(op, idx);
        r.typed        = 1'b1;
        r.want.index   = want_idx;
        r.want.status  = want_st;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic sel, logic [CFG_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    // hold the sender off, then wait for the result stream to drain and idle
    task automatic wait_quiet();
        @(negedge clk);
        start = 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write over the config channel, only called while idle
    task automatic cfg_write(logic sel, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = sel;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (sel)
            CFG_MAX_OBJECTS: limit_reg = val;
            CFG_CHUNK_SIZE:  chunk_reg = val;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one request after a gap of idle cycles counted once the block is free;
    // start stays high when the next follows at once
    task automatic issue(logic op, logic [IDX_W-1:0] idx, int gap, logic typed,
                         grant_t want, output grant_t got);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            while (busy)
                @(negedge clk);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      = 1'b1;
        opcode     = op;
        free_index = idx;
        do
            @(posedge clk);
        while (busy);
        // accepted at this edge
        got = pool_step(op, idx);
        grant_q.push_back(typed ? want : got);
        if (op == OP_FREE)
            n_free = n_free + 1;
        else
        begin
            n_alloc = n_alloc + 1;
            if (got.status == STATUS_EXHAUSTED)
                n_exhausted = n_exhausted + 1;
        end
    endtask

    // result checker: the block cannot be stalled, so every strobe is taken
    always @(posedge clk)
    begin
        grant_t exp_g;
        if (rst_n && done)
        begin
            if (grant_q.size() == 0)
            begin
                $display("%0t: unexpected result index %0d status %0d",
                         $time, object_index, status);
                errors = errors + 1;
            end
            else
            begin
                exp_g = grant_q.pop_front();
                if (object_index !== exp_g.index)
                begin
                    $display("%0t: object_index mismatch: expected %0d, got %0d",
                             $time, exp_g.index, object_index);
                    errors = errors + 1;
                end
                if (status !== exp_g.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, exp_g.status, status);
                    errors = errors + 1;
                end
            end
        end
    end

    initial
    begin
        pool_setting_t phases [6];
        grant_t        got;
        grant_t        none;
        stim_row_t     r;
        logic          op;
        logic [IDX_W-1:0] idx;
        int            gap;
        int            pick;
        int            drain;

        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = OP_ALLOC;
        free_index  = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_MAX_OBJECTS;
        cfg_data    = '0;
        errors      = 0;
        n_alloc     = 0;
        n_free      = 0;
        n_exhausted = 0;
        n_growth    = 0;
        none        = '0;

        // shadow reset state; link memory left unset, never read before written
        head      = CFG_W'(POOL_DEPTH);
        created   = '0;
        limit_reg = MAX_OBJECTS_RESET;
        chunk_reg = CHUNK_SIZE_RESET;

        // directed script: limit of zero, chunk of zero, double free,
        // limit below created count, extreme indices, then plain growth
        script = '{
            cfg_row(CFG_MAX_OBJECTS, 11'd0),
            chk_row(OP_ALLOC, 10'd0,    10'd0,    STATUS_EXHAUSTED),
            chk_row(OP_FREE,  10'd1023, 10'd0,    STATUS_OK),
            chk_row(OP_ALLOC, 10'd0,    10'd1023, STATUS_OK),
            chk_row(OP_ALLOC, 10'd1023, 10'd0,    STATUS_EXHAUSTED),
            cfg_row(CFG_CHUNK_SIZE, 11'd0),
            cfg_row(CFG_MAX_OBJECTS, 11'd3),
            chk_row(OP_ALLOC, 10'd0,    10'd0,    STATUS_OK),
            chk_row(OP_ALLOC, 10'd0,    10'd1,    STATUS_OK),
            chk_row(OP_FREE,  10'd0,    10'd0,    STATUS_OK),
            chk_row(OP_FREE,  10'd0,    10'd0,    STATUS_OK),
            chk_row(OP_ALLOC, 10'd0,    10'd0,    STATUS_OK),
            chk_row(OP_ALLOC, 10'd0,    10'd0,    STATUS_OK),
            chk_row(OP_ALLOC, 10'd0,    10'd2,    STATUS_OK),
            chk_row(OP_ALLOC, 10'd0,    10'd0,    STATUS_EXHAUSTED),
            cfg_row(CFG_MAX_OBJECTS, 11'd2),
            chk_row(OP_FREE,  10'd682,  10'd0,    STATUS_OK),
            req_row(OP_ALLOC, 10'd341),
            chk_row(OP_ALLOC, 10'd0,    10'd0,    STATUS_EXHAUSTED),
            cfg_row(CFG_CHUNK_SIZE, 11'd5),
            cfg_row(CFG_MAX_OBJECTS, 11'd1024),
            req_row(OP_ALLOC, 10'd0),
            req_row(OP_FREE,  10'd341),
            req_row(OP_ALLOC, 10'd0),
            req_row(OP_ALLOC, 10'd0)
        };

        // random phases: limit and chunk per phase; the created count never
        // falls, so limits climb, with two dips and the extremes at the end
        phases[0] = '{11'd64,   11'd1};
        phases[1] = '{11'd200,  11'd7};
        phases[2] = '{11'd100,  11'd3};
        phases[3] = '{11'd420,  11'd64};
        phases[4] = '{11'd1,    11'd1024};
        phases[5] = '{11'd2047, 11'd2047};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        foreach (script[i])
        begin
            r = script[i];
            if (r.kind == ROW_CFG)
            begin
                wait_quiet();
                cfg_write(r.reg_sel, r.reg_val);
            end
            else
                issue(r.op, r.idx, 0, r.typed, r.want, got);
        end

        // random part; each phase starts with the sender held off until
        // every outstanding result is back
        for (int p = 0; p < 6; p++)
        begin
            wait_quiet();
            cfg_write(CFG_MAX_OBJECTS, phases[p].limit);
            cfg_write(CFG_CHUNK_SIZE, phases[p].chunk);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mostly allocations so the list keeps running dry
                op = ($urandom_range(99) < 60) ? OP_ALLOC : OP_FREE;
                if (op == OP_FREE && held.size() != 0 && $urandom_range(99) < 85)
                begin
                    // well-formed return of an object still out
                    pick = $urandom_range(held.size() - 1);
                    idx  = held[pick];
                    held.delete(pick);
                end
                else
                    // stray free (maybe double) or ignored field on allocate
                    idx = IDX_W'($urandom);
                // phase 2 runs with no idle cycles at all
                gap = (p != 2 && $urandom_range(99) < 30) ? $urandom_range(6, 1) : 0;
                issue(op, idx, gap, 1'b0, none, got);
                if (op == OP_ALLOC && got.status == STATUS_OK)
                    held.push_back(got.index);
            end
        end

        @(negedge clk);
        start = 1'b0;

        // drain, then a few quiet cycles to catch stray strobes
        drain = 0;
        while (grant_q.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain = drain + 1;
        end
        repeat (SETTLE_CYCLES * 4) @(posedge clk);

        $display("covered %0d requests: %0d allocate (%0d exhausted), %0d free",
                 n_alloc + n_free, n_alloc, n_exhausted, n_free);
        $display("pool grew %0d times to %0d objects over 6 random settings",
                 n_growth, created);
        if (errors == 0 && grant_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
